// ----- rtl/core/bfha_pkg.sv -----
// Shared types and constants for the best-fit hole allocator.
package bfha_pkg;

  // Widest values the parameter ranges allow; cells slice what they need.
  localparam int SzMaxW  = 32;
  localparam int IdxMaxW = 10;
  localparam int CntMaxW = 11;

  // Fixed widths of the result fields.
  localparam int StatusW = 2;
  localparam int OwnerW  = 16;
  localparam int BlkIdxW = 6;
  localparam int FieldW  = 16;
  localparam int TotalW  = 22;
  localparam int UsedW   = 7;
  localparam int OutDataW = 88;
  localparam int OutPadW  = OutDataW - (StatusW + OwnerW + BlkIdxW + FieldW + TotalW
                                        + FieldW + UsedW);

  typedef enum logic [StatusW-1:0] {
    ST_LOADED = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_NOFIT  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Token that walks the cell row: a best-fit search or a free-space report.
  typedef struct packed {
    logic               valid;
    logic               search;
    logic               found;
    logic [IdxMaxW-1:0] best_idx;
    logic [SzMaxW-1:0]  best_size;
    logic [TotalW-1:0]  total;
    logic [SzMaxW-1:0]  largest;
  } token_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               load_en;
    logic               alloc_en;
    logic               split;
    logic [IdxMaxW-1:0] idx;
    logic [SzMaxW-1:0]  size;
    logic [SzMaxW-1:0]  rem;
    logic [OwnerW-1:0]  owner;
    logic [CntMaxW-1:0] count;
  } ctl_t;

endpackage

// ----- rtl/core/bfha_cell.sv -----
// One table entry of the allocator with its stage of the walking token.
module bfha_cell #(
  parameter int SIZE_BITS = 16,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfha_pkg::ctl_t       ctl_i,
  input  bfha_pkg::token_t     tok_i,
  output bfha_pkg::token_t     tok_o,
  input  logic [SIZE_BITS-1:0] left_size_i,
  input  logic                 left_taken_i,
  input  logic [15:0]          left_owner_i,
  output logic [SIZE_BITS-1:0] size_o,
  output logic                 taken_o,
  output logic [15:0]          owner_o
);
  import bfha_pkg::*;

  logic [SIZE_BITS-1:0] size_q, size_d;
  logic                 taken_q, taken_d;
  logic [OwnerW-1:0]    owner_q, owner_d;
  token_t               tok_q, tok_d;
  logic                 in_use;
  logic [SzMaxW-1:0]    size_x;
  logic [CntMaxW-1:0]   my_pos;
  logic [CntMaxW-1:0]   after_pos;

  assign my_pos    = CntMaxW'(CELL_IDX);
  assign after_pos = {1'b0, ctl_i.idx} + CntMaxW'(1);
  assign in_use    = my_pos < ctl_i.count;
  assign size_x    = SzMaxW'(size_q);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && in_use && !taken_q) begin
      if (tok_i.search) begin
        if (size_x >= ctl_i.size && (!tok_i.found || size_x < tok_i.best_size)) begin
          tok_d.found     = 1'b1;
          tok_d.best_size = size_x;
          tok_d.best_idx  = IdxMaxW'(CELL_IDX);
        end
      end else begin
        tok_d.total = tok_i.total + TotalW'(size_q);
        if (size_x > tok_i.largest) begin
          tok_d.largest = size_x;
        end
      end
    end
  end

  // Entry update: load write, grant, remainder insert, or move up by one place.
  always_comb begin
    size_d  = size_q;
    taken_d = taken_q;
    owner_d = owner_q;
    if (ctl_i.load_en && my_pos == {1'b0, ctl_i.idx}) begin
      size_d  = ctl_i.size[SIZE_BITS-1:0];
      taken_d = 1'b0;
      owner_d = '0;
    end else if (ctl_i.alloc_en) begin
      if (my_pos == {1'b0, ctl_i.idx}) begin
        size_d  = ctl_i.size[SIZE_BITS-1:0];
        taken_d = 1'b1;
        owner_d = ctl_i.owner;
      end else if (ctl_i.split && my_pos == after_pos) begin
        size_d  = ctl_i.rem[SIZE_BITS-1:0];
        taken_d = 1'b0;
        owner_d = '0;
      end else if (ctl_i.split && my_pos > after_pos) begin
        size_d  = left_size_i;
        taken_d = left_taken_i;
        owner_d = left_owner_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    taken_q <= taken_d;
    owner_q <= owner_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign size_o  = size_q;
  assign taken_o = taken_q;
  assign owner_o = owner_q;

endmodule

// ----- rtl/core/best_fit_hole_allocator_core.sv -----
// Top level of the best-fit hole allocator: controller and the row of cells.
//
// Input channel (s_axis): tuser carries the command (0 append a free hole,
// 1 allocate), tdata carries the size. Output channel (m_axis): one result
// beat per input beat with status, owner id, block index, original size,
// free total, largest hole and entries in use.
// Each table entry lives in its own cell. A token walks the row one cell per
// cycle: first a best-fit search for an allocate, then a report pass that
// sums the free sizes and finds the largest hole after the table update.
// A split shifts all later entries up by one place at once, in the update state.
// An allocate walks the token along the row twice, a search and a report,
// and a load walks it once for the report.
// One item is in work at a time; the next input beat is taken while the
// previous result still waits in the output register.
// Reset empties the table and clears the request number; entry contents are
// not cleared. A stalled receiver holds the result, and the block then stops
// once the next result is ready to be shown.
module best_fit_hole_allocator_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int SIZE_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // size
  input  logic [0:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, owner_id, block_index, original_size, free_total, largest_hole,
  // entries_used, zero padding
  output logic [87:0] m_axis_tdata
);
  import bfha_pkg::*;

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SRCH_GO = 7'b0000010,
    S_SEARCH  = 7'b0000100,
    S_UPDATE  = 7'b0001000,
    S_RPT_GO  = 7'b0010000,
    S_REPORT  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e               state_q;
  logic                 cmd_q;
  logic [SIZE_BITS-1:0] sz_q;
  logic [CntW-1:0]      count_q;
  logic [OwnerW-1:0]    req_q;
  status_e              status_q;
  logic [OwnerW-1:0]    res_owner_q;
  logic [IdxW-1:0]      res_idx_q;
  logic [SIZE_BITS-1:0] orig_q;
  logic [SIZE_BITS-1:0] rem_q;
  logic                 split_q;
  logic [TotalW-1:0]    total_q;
  logic [SIZE_BITS-1:0] largest_q;
  logic                 m_valid_q;
  logic [OutDataW-1:0]  m_data_q;

  ctl_t                 ctl;
  token_t               tok [TABLE_DEPTH+1];
  logic [SIZE_BITS-1:0] ch_size  [TABLE_DEPTH];
  logic                 ch_taken [TABLE_DEPTH];
  logic [OwnerW-1:0]    ch_owner [TABLE_DEPTH];

  logic                 in_fire;
  logic                 full;
  logic [SIZE_BITS-1:0] in_size;
  logic [SIZE_BITS-1:0] best_size;
  logic [SIZE_BITS-1:0] best_rem;
  logic                 out_load;
  logic [OutDataW-1:0]  out_word;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(TABLE_DEPTH));
  assign in_size       = SIZE_BITS'(s_axis_tdata);
  assign best_size     = tok[TABLE_DEPTH].best_size[SIZE_BITS-1:0];
  assign best_rem      = best_size - sz_q;
  assign out_load      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    ctl          = '0;
    ctl.load_en  = (state_q == S_UPDATE) && !cmd_q;
    ctl.alloc_en = (state_q == S_UPDATE) && cmd_q;
    ctl.split    = split_q;
    ctl.idx      = IdxMaxW'(res_idx_q);
    ctl.size     = SzMaxW'(sz_q);
    ctl.rem      = SzMaxW'(rem_q);
    ctl.owner    = res_owner_q;
    ctl.count    = CntMaxW'(count_q);
  end

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = (state_q == S_SRCH_GO) || (state_q == S_RPT_GO);
    tok[0].search = (state_q == S_SRCH_GO);
  end

  assign ch_size[0]  = '0;
  assign ch_taken[0] = 1'b0;
  assign ch_owner[0] = '0;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k < TABLE_DEPTH - 1) begin : g_mid
      bfha_cell #(
        .SIZE_BITS(SIZE_BITS),
        .CELL_IDX (k)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .tok_i       (tok[k]),
        .tok_o       (tok[k+1]),
        .left_size_i (ch_size[k]),
        .left_taken_i(ch_taken[k]),
        .left_owner_i(ch_owner[k]),
        .size_o      (ch_size[k+1]),
        .taken_o     (ch_taken[k+1]),
        .owner_o     (ch_owner[k+1])
      );
    end else begin : g_last
      bfha_cell #(
        .SIZE_BITS(SIZE_BITS),
        .CELL_IDX (k)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .tok_i       (tok[k]),
        .tok_o       (tok[k+1]),
        .left_size_i (ch_size[k]),
        .left_taken_i(ch_taken[k]),
        .left_owner_i(ch_owner[k]),
        .size_o      (),
        .taken_o     (),
        .owner_o     ()
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      req_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser[0]) begin
              req_q   <= req_q + OwnerW'(1);
              state_q <= S_SRCH_GO;
            end else if (full) begin
              state_q <= S_RPT_GO;
            end else begin
              state_q <= S_UPDATE;
            end
          end
        end
        S_SRCH_GO: state_q <= S_SEARCH;
        S_SEARCH: begin
          if (tok[TABLE_DEPTH].valid) begin
            if (!tok[TABLE_DEPTH].found || (best_rem != '0 && full)) begin
              state_q <= S_RPT_GO;
            end else begin
              state_q <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          if (!cmd_q || split_q) begin
            count_q <= count_q + CntW'(1);
          end
          state_q <= S_RPT_GO;
        end
        S_RPT_GO: state_q <= S_REPORT;
        S_REPORT: begin
          if (tok[TABLE_DEPTH].valid) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result fields and operands; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= s_axis_tuser[0];
      sz_q    <= in_size;
      split_q <= 1'b0;
      if (s_axis_tuser[0]) begin
        res_owner_q <= req_q + OwnerW'(1);
      end else if (full) begin
        status_q    <= ST_FULL;
        res_owner_q <= '0;
        res_idx_q   <= '0;
        orig_q      <= '0;
      end else begin
        status_q    <= ST_LOADED;
        res_owner_q <= '0;
        res_idx_q   <= count_q[IdxW-1:0];
        orig_q      <= in_size;
      end
    end
    if (state_q == S_SEARCH && tok[TABLE_DEPTH].valid) begin
      if (!tok[TABLE_DEPTH].found) begin
        status_q  <= ST_NOFIT;
        res_idx_q <= '0;
        orig_q    <= '0;
      end else begin
        status_q  <= (best_rem != '0 && full) ? ST_FULL : ST_ALLOC;
        res_idx_q <= tok[TABLE_DEPTH].best_idx[IdxW-1:0];
        orig_q    <= best_size;
        rem_q     <= best_rem;
        split_q   <= (best_rem != '0);
      end
    end
    if (state_q == S_REPORT && tok[TABLE_DEPTH].valid) begin
      total_q   <= tok[TABLE_DEPTH].total;
      largest_q <= tok[TABLE_DEPTH].largest[SIZE_BITS-1:0];
    end
  end

  assign out_word = {OutPadW'(0), UsedW'(count_q), FieldW'(largest_q), total_q,
                     FieldW'(orig_q), BlkIdxW'(res_idx_q), res_owner_q, status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= out_word;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- sim/best_fit_hole_allocator_core_checker.sv -----
// Checker for the best-fit hole allocator: predicts each result and compares it.
`timescale 1ns / 1ps

module best_fit_hole_allocator_core_checker #(
  parameter int TableDepth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // size
  input  logic [0:0]  s_tuser_i,   // cmd
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [87:0] m_tdata_i,   // status, owner_id, block_index, original_size,
                                   // free_total, largest_hole, entries_used, padding
  output int          errors_o,
  output int          pending_o,
  output int          beats_in_o,
  output int          n_loaded_o,
  output int          n_granted_o,
  output int          n_missed_o,
  output int          n_full_o
);
  import bfha_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [15:0] owner_id;
    logic [5:0]  block_index;
    logic [15:0] original_size;
    logic [21:0] free_total;
    logic [15:0] largest_hole;
    logic [6:0]  entries_used;
  } grant_report_t;

  // Shadow copy of the block table.
  logic [15:0] hole_size  [TableDepth];
  logic        hole_taken [TableDepth];
  logic [15:0] hole_owner [TableDepth];
  int          blocks_used;
  logic [15:0] request_num;

  grant_report_t expected_reports[$];
  int            errors;

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    end
  endtask

  function automatic grant_report_t predict_report(input logic alloc_req,
                                                   input logic [15:0] req_size);
    grant_report_t r;
    int            best;
    logic          found;
    logic [15:0]   orig;
    logic [15:0]   rem;
    logic [21:0]   sum;
    logic [15:0]   biggest;
    r = '0;
    if (!alloc_req) begin
      if (blocks_used >= TableDepth) begin
        r.status = ST_FULL;
      end else begin
        hole_size[blocks_used]  = req_size;
        hole_taken[blocks_used] = 1'b0;
        hole_owner[blocks_used] = '0;
        r.status        = ST_LOADED;
        r.block_index   = blocks_used[5:0];
        r.original_size = req_size;
        blocks_used++;
      end
    end else begin
      request_num = request_num + 16'd1;
      r.owner_id  = request_num;
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < blocks_used; i++) begin
        if (!hole_taken[i] && hole_size[i] >= req_size &&
            (!found || hole_size[i] < hole_size[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_NOFIT;
      end else begin
        orig = hole_size[best];
        rem  = orig - req_size;
        r.block_index   = best[5:0];
        r.original_size = orig;
        if (rem != 0 && blocks_used >= TableDepth) begin
          // A split would need one more entry than the table holds.
          r.status = ST_FULL;
        end else begin
          hole_taken[best] = 1'b1;
          hole_size[best]  = req_size;
          hole_owner[best] = request_num;
          if (rem != 0) begin
            for (int i = blocks_used; i > best + 1; i--) begin
              hole_size[i]  = hole_size[i-1];
              hole_taken[i] = hole_taken[i-1];
              hole_owner[i] = hole_owner[i-1];
            end
            hole_size[best+1]  = rem;
            hole_taken[best+1] = 1'b0;
            hole_owner[best+1] = '0;
            blocks_used++;
          end
          r.status = ST_ALLOC;
        end
      end
    end
    sum     = '0;
    biggest = '0;
    for (int i = 0; i < blocks_used; i++) begin
      if (!hole_taken[i]) begin
        sum = sum + hole_size[i];
        if (hole_size[i] > biggest) begin
          biggest = hole_size[i];
        end
      end
    end
    r.free_total   = sum;
    r.largest_hole = biggest;
    r.entries_used = blocks_used[6:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_report_t want;
    if (!rst_ni) begin
      blocks_used = 0;
      request_num = '0;
      expected_reports.delete();
      errors      = 0;
      beats_in_o  = 0;
      n_loaded_o  = 0;
      n_granted_o = 0;
      n_missed_o  = 0;
      n_full_o    = 0;
    end else begin
      // Results are retired before new beats are predicted, so a stray result
      // can never be matched against an expectation made at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_reports.pop_front();
          if (m_tdata_i[1:0] != want.status)
            report_mismatch("status", m_tdata_i[1:0], want.status);
          if (m_tdata_i[17:2] != want.owner_id)
            report_mismatch("owner_id", m_tdata_i[17:2], want.owner_id);
          if (m_tdata_i[23:18] != want.block_index)
            report_mismatch("block_index", m_tdata_i[23:18], want.block_index);
          if (m_tdata_i[39:24] != want.original_size)
            report_mismatch("original_size", m_tdata_i[39:24], want.original_size);
          if (m_tdata_i[61:40] != want.free_total)
            report_mismatch("free_total", m_tdata_i[61:40], want.free_total);
          if (m_tdata_i[77:62] != want.largest_hole)
            report_mismatch("largest_hole", m_tdata_i[77:62], want.largest_hole);
          if (m_tdata_i[84:78] != want.entries_used)
            report_mismatch("entries_used", m_tdata_i[84:78], want.entries_used);
          case (want.status)
            ST_LOADED: n_loaded_o++;
            ST_ALLOC:  n_granted_o++;
            ST_NOFIT:  n_missed_o++;
            default:   n_full_o++;
          endcase
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_reports.push_back(predict_report(s_tuser_i[0], s_tdata_i));
        beats_in_o++;
      end
    end
    errors_o  = errors;
    pending_o = expected_reports.size();
  end

endmodule

// ----- sim/best_fit_hole_allocator_core_tb.sv -----
// Testbench top for the best-fit hole allocator: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module best_fit_hole_allocator_core_tb;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdAlloc = 1'b1;
  localparam int   RandomBeats = 1750;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  logic sink_hold = 1'b0;
  logic hold_trigger = 1'b0;

  int errors, pending, beats_in, n_loaded, n_granted, n_missed, n_full;

  best_fit_hole_allocator_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  best_fit_hole_allocator_core_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending),
    .beats_in_o (beats_in),
    .n_loaded_o (n_loaded),
    .n_granted_o(n_granted),
    .n_missed_o (n_missed),
    .n_full_o   (n_full)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, plus a long hold while sink_hold is set.
  initial begin
    forever begin
      @(posedge clk_i);
      m_axis_tready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // One long receiver stall so that the output register and the block fill up.
  initial begin
    wait (hold_trigger);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (700) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  // The limit allows several times the slowest correct run of about 1800 beats.
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_beat(input logic cmd, input logic [15:0] size);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= size;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] size;
    logic        cmd;
    int          pick;
    int          guard;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: empty-table misses, zero-size requests, ties, exact
    // fits, splits and the extreme sizes.
    send_beat(CmdAlloc, 16'd5);
    send_beat(CmdAlloc, 16'd0);
    send_beat(CmdLoad,  16'hFFFF);
    send_beat(CmdLoad,  16'd100);
    send_beat(CmdLoad,  16'd100);
    // Zero-size request takes the smallest hole and leaves all of it over.
    send_beat(CmdAlloc, 16'd0);
    send_beat(CmdLoad,  16'd0);
    send_beat(CmdAlloc, 16'd0);
    send_beat(CmdAlloc, 16'd100);
    send_beat(CmdAlloc, 16'hFFFF);
    send_beat(CmdAlloc, 16'hFFFF);
    send_beat(CmdAlloc, 16'd1);
    send_beat(CmdLoad,  16'h8000);
    send_beat(CmdAlloc, 16'h7FFF);
    send_beat(CmdAlloc, 16'hAAAA);
    send_beat(CmdLoad,  16'h5555);
    send_beat(CmdAlloc, 16'h5555);

    // Random part in four idling phases. Loads are rare so that the table
    // fills gradually; once it is full, loads and splits report a full table.
    for (int n = 0; n < RandomBeats; n++) begin
      case (n / (RandomBeats / 4))
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 48; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 48; end
        default: begin src_idle_pct = 10; snk_stall_pct = 10; end
      endcase
      if (n == 100) begin
        hold_trigger = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        cmd = CmdLoad;
        case ($urandom_range(2))
          0:       size = 16'hFFFF;
          1:       size = 16'($urandom_range(1, 16));
          default: size = 16'($urandom);
        endcase
      end else begin
        cmd  = CmdAlloc;
        pick = $urandom_range(99);
        if (pick < 10)      size = 16'd0;
        else if (pick < 50) size = 16'($urandom_range(1, 16));
        else if (pick < 75) size = 16'($urandom_range(0, 1023));
        else                size = 16'($urandom);
      end
      send_beat(cmd, size);
    end
    s_axis_tvalid <= 1'b0;
    snk_stall_pct = 0;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    // Let any late or stray result beat show up.
    repeat (300) @(posedge clk_i);

    $display("Run covered %0d input beats: %0d holes loaded, %0d grants,",
             beats_in, n_loaded, n_granted);
    $display("%0d requests without a fitting hole and %0d table-full results.",
             n_missed, n_full);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bfha_pkg.sv
rtl/core/bfha_cell.sv
rtl/core/best_fit_hole_allocator_core.sv
sim/best_fit_hole_allocator_core_checker.sv
sim/best_fit_hole_allocator_core_tb.sv
